/* sv/mcpt_pkg.sv */
// Package for the multi-channel periodic timer: item structs, command codes,
// per-timer row and update types, and the sequencer state encoding.
// No dependencies; used by the top level and mcpt_unit.
package mcpt_pkg;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_STOP   = 2'd1;
   localparam logic [1:0] KIND_PERIOD = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   localparam int MAX_RESULTS = 32;
   localparam int CNT_WIDTH   = 6;
   localparam int IDX_WIDTH   = 9;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  timer_index;
      logic [31:0] period_ticks;
      logic [31:0] repeat_limit;
      logic [30:0] start_stage;
   } req_type;

   typedef struct packed {
      logic [4:0]  timer_id;
      logic [31:0] stage_number;
      logic        last_event;
   } rsp_type;

   typedef struct packed {
      logic [31:0] period;
      logic [31:0] ticks;
      logic [31:0] stage;
      logic [31:0] limit;
   } row_type;

   typedef struct packed {
      logic        fire;
      logic        run;
      logic [31:0] period;
      logic [31:0] ticks;
      logic [31:0] stage;
      logic [31:0] stage_out;
   } upd_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

endpackage

/* sv/multi_channel_periodic_timer.sv */
// Top level of the multi-channel periodic timer: command sequencer, timer scan,
// result holding and output registers. Depends on mcpt_pkg, mcpt_ram, mcpt_unit.
//
//   port group   dir   handshake              payload
//   req_*        in    req_valid/req_ready    req_item (mcpt_pkg::req_type)
//   rsp_*        out   rsp_valid/rsp_ready    rsp_item (mcpt_pkg::rsp_type)
//
// Stop and set-period complete in the accept cycle. A start goes through RAM read,
// update and final flush. A tick goes through the accept cycle, one scan step per
// timer plus a final one, one update step per running timer and the final flush.
// A stalled result output holds the scan at the next firing timer.
// Reset clears run flags and stored-period valid bits; no clearing pass.
module multi_channel_periodic_timer #(
   parameter int          NUM_TIMERS     = 32,
   parameter logic [31:0] DEFAULT_PERIOD = 32'd1000000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcpt_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcpt_pkg::rsp_type rsp_item
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = IW + 1;

   mcpt_pkg::state_type state_ff, state_in;
   mcpt_pkg::req_type   cmd_ff, cmd_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic [mcpt_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [NUM_TIMERS-1:0] running_ff, running_in;
   logic [NUM_TIMERS-1:0] pvalid_ff, pvalid_in;
   mcpt_pkg::rsp_type   hold_ff, hold_in;
   logic                hold_valid_ff, hold_valid_in;
   mcpt_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [mcpt_pkg::IDX_WIDTH-1:0] idx_ext;
   logic [mcpt_pkg::IDX_WIDTH-1:0] cur_ext;
   logic          idx_ok;
   logic [IW-1:0] idx_addr;
   logic [IW-1:0] scan_addr;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic          per_we, tck_we, stg_we, lim_we;
   logic [31:0]   per_wd;
   logic [31:0]   rd_period, rd_ticks, rd_stage, rd_limit;
   mcpt_pkg::row_type row;
   mcpt_pkg::upd_type upd;
   logic          is_start;
   logic          room;
   logic          out_free;
   logic          accept;

   assign idx_ext   = mcpt_pkg::IDX_WIDTH'(req_item.timer_index);
   assign idx_ok    = idx_ext < mcpt_pkg::IDX_WIDTH'(NUM_TIMERS);
   assign idx_addr  = idx_ext[IW-1:0];
   assign scan_addr = scan_ff[IW-1:0];
   assign cur_ext   = mcpt_pkg::IDX_WIDTH'(cur_ff);
   assign is_start  = (cmd_ff.kind == mcpt_pkg::KIND_START);
   assign room      = cnt_ff < mcpt_pkg::CNT_WIDTH'(mcpt_pkg::MAX_RESULTS);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mcpt_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      row.period = pvalid_ff[cur_ff] ? rd_period : DEFAULT_PERIOD;
      row.ticks  = rd_ticks;
      row.stage  = rd_stage;
      row.limit  = rd_limit;
   end

   mcpt_unit u_unit (
      .is_start (is_start),
      .room     (room),
      .cmd      (cmd_ff),
      .row      (row),
      .upd      (upd)
   );

   mcpt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_period_ram (
      .clock(clock), .wr_en(per_we), .wr_addr(wr_addr), .wr_data(per_wd),
      .rd_addr(rd_addr), .rd_data(rd_period)
   );

   mcpt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_ticks_ram (
      .clock(clock), .wr_en(tck_we), .wr_addr(wr_addr), .wr_data(upd.ticks),
      .rd_addr(rd_addr), .rd_data(rd_ticks)
   );

   mcpt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_stage_ram (
      .clock(clock), .wr_en(stg_we), .wr_addr(wr_addr), .wr_data(upd.stage),
      .rd_addr(rd_addr), .rd_data(rd_stage)
   );

   mcpt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_limit_ram (
      .clock(clock), .wr_en(lim_we), .wr_addr(wr_addr), .wr_data(cmd_ff.repeat_limit),
      .rd_addr(rd_addr), .rd_data(rd_limit)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      cnt_in        = cnt_ff;
      running_in    = running_ff;
      pvalid_in     = pvalid_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rd_addr       = cur_ff;
      wr_addr       = cur_ff;
      per_we        = 1'b0;
      tck_we        = 1'b0;
      stg_we        = 1'b0;
      lim_we        = 1'b0;
      per_wd        = upd.period;

      case (state_ff)
         mcpt_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in = req_item;
               cnt_in = '0;
               case (req_item.kind)
                  mcpt_pkg::KIND_START: begin
                     if (idx_ok) begin
                        cur_in   = idx_addr;
                        rd_addr  = idx_addr;
                        state_in = mcpt_pkg::ST_EXEC;
                     end
                  end
                  mcpt_pkg::KIND_STOP: begin
                     if (idx_ok) begin
                        running_in[idx_addr] = 1'b0;
                     end
                  end
                  mcpt_pkg::KIND_PERIOD: begin
                     if (idx_ok) begin
                        wr_addr             = idx_addr;
                        per_we              = 1'b1;
                        per_wd              = (req_item.period_ticks == 32'd0) ?
                                              32'd1 : req_item.period_ticks;
                        pvalid_in[idx_addr] = 1'b1;
                     end
                  end
                  default: begin
                     scan_in  = '0;
                     state_in = mcpt_pkg::ST_SCAN;
                  end
               endcase
            end
         end
         mcpt_pkg::ST_SCAN: begin
            if (scan_ff == CW'(NUM_TIMERS)) begin
               state_in = mcpt_pkg::ST_FLUSH;
            end else if (running_ff[scan_addr]) begin
               cur_in   = scan_addr;
               rd_addr  = scan_addr;
               state_in = mcpt_pkg::ST_EXEC;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         mcpt_pkg::ST_EXEC: begin
            if (!(upd.fire && hold_valid_ff && !out_free)) begin
               tck_we             = 1'b1;
               stg_we             = 1'b1;
               running_in[cur_ff] = upd.run;
               if (is_start) begin
                  per_we            = 1'b1;
                  lim_we            = 1'b1;
                  pvalid_in[cur_ff] = 1'b1;
                  state_in          = mcpt_pkg::ST_FLUSH;
               end else begin
                  scan_in  = scan_ff + CW'(1);
                  state_in = mcpt_pkg::ST_SCAN;
               end
               if (upd.fire) begin
                  cnt_in = cnt_ff + mcpt_pkg::CNT_WIDTH'(1);
                  if (hold_valid_ff) begin
                     rsp_in       = hold_ff;
                     rsp_valid_in = 1'b1;
                  end
                  hold_in.timer_id     = cur_ext[4:0];
                  hold_in.stage_number = upd.stage_out;
                  hold_in.last_event   = 1'b0;
                  hold_valid_in        = 1'b1;
               end
            end
         end
         mcpt_pkg::ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = mcpt_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_in            = hold_ff;
               rsp_in.last_event = 1'b1;
               rsp_valid_in      = 1'b1;
               hold_valid_in     = 1'b0;
               state_in          = mcpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mcpt_pkg::ST_IDLE;
         cnt_ff        <= '0;
         scan_ff       <= '0;
         running_ff    <= '0;
         pvalid_ff     <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         scan_ff       <= scan_in;
         running_ff    <= running_in;
         pvalid_ff     <= pvalid_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      cur_ff  <= cur_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcpt_pkg::ST_IDLE) |-> !hold_valid_ff)
      else $error("held result left behind in idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= mcpt_pkg::CNT_WIDTH'(mcpt_pkg::MAX_RESULTS))
      else $error("result count beyond limit");

   a_flush_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcpt_pkg::ST_FLUSH && !hold_valid_ff) |=> (state_ff == mcpt_pkg::ST_IDLE))
      else $error("flush did not return to idle");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcpt_pkg::ST_SCAN) |-> !(per_we || tck_we || stg_we || lim_we))
      else $error("state write during scan");

endmodule

/* sv/mcpt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds one field of the per-timer state.
module mcpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mcpt_unit.sv */
// Shared update unit: decides whether one timer fires and computes its new
// countdown, stage and run flag for a start command or a tick.
// Depends on mcpt_pkg.
module mcpt_unit (
   input  logic             is_start,
   input  logic             room,
   input  mcpt_pkg::req_type cmd,
   input  mcpt_pkg::row_type row,
   output mcpt_pkg::upd_type upd
);

   logic [31:0] per;
   logic [31:0] eff;
   logic [31:0] cur_stage;
   logic [31:0] cur_lim;
   logic [31:0] inc;
   logic        stop_hit;
   logic        due;

   always_comb begin
      per       = (is_start && cmd.period_ticks != 32'd0) ? cmd.period_ticks : row.period;
      eff       = (per == 32'd0) ? 32'd1 : per;
      cur_stage = is_start ? {1'b0, cmd.start_stage} : row.stage;
      cur_lim   = is_start ? cmd.repeat_limit : row.limit;
      inc       = cur_stage + 32'd1;
      stop_hit  = (cur_lim != 32'd0) && (inc >= cur_lim);
      due       = (row.ticks <= 32'd1);

      upd.period    = per;
      upd.stage_out = cur_stage;
      if (is_start) begin
         upd.fire  = (cur_lim == 32'd0) || (cur_stage < cur_lim);
         upd.ticks = eff;
      end else begin
         upd.fire  = due && room;
         upd.ticks = !due ? row.ticks - 32'd1 : (room ? eff : 32'd1);
      end
      upd.stage = upd.fire ? inc : cur_stage;
      upd.run   = is_start ? (upd.fire && !stop_hit) : !(upd.fire && stop_hit);
   end

endmodule
